// ===== rtl/core/lc3x_pkg.sv =====
package lc3x_pkg;

    localparam int ADDR_BITS_DEF = 16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_IND
    } state_t;

    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_LDI  = 4'd9;
    localparam logic [3:0] OP_LEA  = 4'd12;
    localparam logic [3:0] OP_TRAP = 4'd13;
    localparam logic [3:0] OP_RSV0 = 4'd14;
    localparam logic [3:0] OP_RSV1 = 4'd15;

    localparam logic [7:0] TRAP_STOP_CODE = 8'h25;
    localparam logic [7:0] TRAP_CONS_LO   = 8'h20;
    localparam logic [7:0] TRAP_CONS_HI   = 8'h24;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_OP   = 2'd1;
    localparam logic [1:0] STAT_BAD_TRAP = 2'd2;
    localparam logic [1:0] STAT_UNIMPL   = 2'd3;

    localparam logic [2:0] FLAG_N = 3'b100;
    localparam logic [2:0] FLAG_Z = 3'b010;
    localparam logic [2:0] FLAG_P = 3'b001;

    localparam logic KIND_LOAD = 1'b0;

    function automatic logic [15:0] sext9(input logic [15:0] w);
        return {{7{w[8]}}, w[8:0]};
    endfunction

    function automatic logic [15:0] sext5(input logic [15:0] w);
        return {{11{w[4]}}, w[4:0]};
    endfunction

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        logic [2:0] f;
        if (v == 16'd0) begin
            f = FLAG_Z;
        end else if (v[15]) begin
            f = FLAG_N;
        end else begin
            f = FLAG_P;
        end
        return f;
    endfunction

endpackage

// ===== rtl/core/lc3_subset_execute_core.sv =====
// channel | dir | tdata (low bit up)                          | tuser
// s_      | in  | load_address[15:0], load_data[31:16]       | kind
// m_      | out | pc_after, fetched_word, dest_written,       | -
//         |     | dest_index, dest_value, cond_flags,         |
//         |     | halted_now, step_status; zero pad to 64     |
// A step passes IDLE (fetch), FETCH (data read) and EXEC, and LDI adds IND for
// the indirect read on the single-port word memory; a load beat is done in IDLE.
// After reset a clearing pass writes zero to all 2**ADDR_BITS words, one per
// cycle; s_tready stays low meanwhile. A one-beat input buffer takes the next
// beat while the engine works; the output register holds a result until taken.
module lc3_subset_execute_core
    import lc3x_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // load_address[15:0], load_data[31:16]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // pc_after, fetched_word, dest_written, dest_index,
                                   // dest_value, cond_flags, halted_now, step_status
);

    localparam int MemWords = 1 << ADDR_BITS;

    state_t state_reg, state_next;

    logic        buf_valid_reg, buf_valid_next;
    logic        buf_kind_reg;
    logic [15:0] buf_addr_reg, buf_data_reg;

    logic [15:0] pc_reg, pc_next;
    logic [2:0]  flags_reg, flags_next;
    logic        halt_reg, halt_next;
    logic [15:0] ir_reg;
    logic [ADDR_BITS-1:0] clr_cnt_reg, clr_cnt_next;

    logic [15:0] mem [0:MemWords-1];
    logic [15:0] mem_rdata_reg;
    logic        mem_we, mem_re;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [15:0] mem_wdata;

    logic [15:0] rf_mem [0:7];
    logic [7:0]  rf_valid_reg;
    logic [15:0] rf_a_reg, rf_b_reg;
    logic        rf_a_ok_reg, rf_b_ok_reg;
    logic        rf_re, rf_we;
    logic [15:0] rf_a, rf_b;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;

    logic        accept, buf_pop, ir_load, done, out_free;
    logic [15:0] pc_inc, fetch_ea, add_b;
    logic [3:0]  op;
    logic        res_written;
    logic [2:0]  res_idx;
    logic [15:0] res_value, res_fetched;
    logic [1:0]  res_status;

    assign s_tready = (!buf_valid_reg || buf_pop) && (state_reg != ST_CLEAR);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign pc_inc   = pc_reg + 16'd1;
    assign fetch_ea = pc_inc + sext9(mem_rdata_reg);
    assign op       = ir_reg[15:12];
    assign rf_a     = rf_a_ok_reg ? rf_a_reg : 16'd0;
    assign rf_b     = rf_b_ok_reg ? rf_b_reg : 16'd0;
    assign add_b    = ir_reg[5] ? sext5(ir_reg) : rf_b;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (buf_valid_reg && buf_kind_reg != KIND_LOAD && !halt_reg) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (op == OP_LDI) begin
                    state_next = ST_IND;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IND: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and datapath
    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = buf_addr_reg[ADDR_BITS-1:0];
        mem_wdata    = buf_data_reg;
        mem_re       = 1'b0;
        mem_raddr    = pc_reg[ADDR_BITS-1:0];
        rf_re        = 1'b0;
        buf_pop      = 1'b0;
        ir_load      = 1'b0;
        done         = 1'b0;
        res_written  = 1'b0;
        res_idx      = 3'd0;
        res_value    = 16'd0;
        res_fetched  = ir_reg;
        res_status   = STAT_OK;
        pc_next      = pc_reg;
        halt_next    = halt_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 16'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                res_fetched = 16'd0;
                if (buf_valid_reg) begin
                    if (buf_kind_reg == KIND_LOAD || halt_reg) begin
                        if (out_free) begin
                            mem_we  = (buf_kind_reg == KIND_LOAD);
                            buf_pop = 1'b1;
                            done    = 1'b1;
                        end
                    end else begin
                        mem_re  = 1'b1;
                        buf_pop = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                ir_load   = 1'b1;
                rf_re     = 1'b1;
                pc_next   = pc_inc;
                mem_re    = 1'b1;
                mem_raddr = fetch_ea[ADDR_BITS-1:0];
            end
            ST_EXEC: begin
                res_idx = ir_reg[11:9];
                unique case (op)
                    OP_ADD: begin
                        res_written = 1'b1;
                        res_value   = rf_a + add_b;
                    end
                    OP_LD: begin
                        res_written = 1'b1;
                        res_value   = mem_rdata_reg;
                    end
                    OP_LDI: begin
                        res_written = 1'b1;
                    end
                    OP_LEA: begin
                        res_written = 1'b1;
                        res_value   = pc_reg + sext9(ir_reg);
                    end
                    OP_TRAP: begin
                        if (ir_reg[7:0] == TRAP_STOP_CODE) begin
                            halt_next = out_free;
                        end else if (ir_reg[7:0] < TRAP_CONS_LO
                                     || ir_reg[7:0] > TRAP_CONS_HI) begin
                            res_status = STAT_BAD_TRAP;
                        end
                    end
                    OP_RSV0, OP_RSV1: res_status = STAT_BAD_OP;
                    default:          res_status = STAT_UNIMPL;
                endcase
                if (!res_written) begin
                    res_idx = 3'd0;
                end
                if (op == OP_LDI) begin
                    mem_re    = 1'b1;
                    mem_raddr = mem_rdata_reg[ADDR_BITS-1:0];
                end else begin
                    done = out_free;
                end
            end
            ST_IND: begin
                res_written = 1'b1;
                res_idx     = ir_reg[11:9];
                res_value   = mem_rdata_reg;
                done        = out_free;
            end
            default: ;
        endcase
    end

    assign rf_we      = done && res_written;
    assign flags_next = rf_we ? flags_of(res_value) : flags_reg;

    always_comb begin
        buf_valid_next = buf_valid_reg;
        if (accept) begin
            buf_valid_next = 1'b1;
        end else if (buf_pop) begin
            buf_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, res_status, halt_next, flags_next, res_value,
                             res_idx, res_written, res_fetched, pc_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            buf_valid_reg <= 1'b0;
            pc_reg        <= 16'd0;
            flags_reg     <= 3'd0;
            halt_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            rf_valid_reg  <= 8'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            pc_reg        <= pc_next;
            flags_reg     <= flags_next;
            halt_reg      <= halt_next;
            clr_cnt_reg   <= clr_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (rf_we) begin
                rf_valid_reg[res_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            buf_kind_reg <= s_tuser;
            buf_addr_reg <= s_tdata[15:0];
            buf_data_reg <= s_tdata[31:16];
        end
        if (ir_load) begin
            ir_reg <= mem_rdata_reg;
        end
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // register file: one write port, two read ports, unwritten entries read zero
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[res_idx] <= res_value;
        end
        if (rf_re) begin
            rf_a_reg    <= rf_mem[mem_rdata_reg[8:6]];
            rf_b_reg    <= rf_mem[mem_rdata_reg[2:0]];
            rf_a_ok_reg <= rf_valid_reg[mem_rdata_reg[8:6]];
            rf_b_ok_reg <= rf_valid_reg[mem_rdata_reg[2:0]];
        end
    end

endmodule
